FILE: rtl/multi_pool_block_allocator_top_macros.svh
// assertion macros used by the allocator top
`ifndef MULTI_POOL_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define MULTI_POOL_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define MPBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define MPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mpba_pkg.sv
// shared types and constants of the block pool allocator
`default_nettype none
package mpba_pkg;
	localparam int NPOOLS = 3;
	localparam int SIZE_W = 13;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 3;
	localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_RESIZE = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_EXTERNAL = 2'd1;
	localparam logic [1:0] ST_FAILED = 2'd2;
	localparam logic [1:0] ST_UNDERFLOW = 2'd3;

	localparam logic [1:0] POOL_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_POOLS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_B = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_C = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_C = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REGION,
		S_FIND,
		S_ALLOC_RD,
		S_ALLOC_WB,
		S_DIV_GO,
		S_DIV,
		S_PUSH,
		S_RESP
	} state_t;

	typedef struct packed {
		logic pop;
		logic push;
		logic [1:0] pool;
	} stack_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/multi_pool_block_allocator_top.sv
// Fixed-size block allocator over three pools, each a LIFO of free block indices held in
// one shared single-port ram (3*MAX_BLOCKS entries, registered read). One item is worked at a
// time. Its steps: allocate: accept, search and ram read, offset multiply, response; resize
// that keeps its block: accept, region end multiply, region check, response; null release or
// unknown function: accept, response; release: accept, region end multiply, region check,
// the bit-serial divider that turns the byte offset into a block index, push, response;
// resize that moves a block: accept, region end multiply, region check, search and ram read,
// offset multiply (skipped when no pool has room), divider, push, response. A stalled output
// holds the block in its response state. No clearing pass is needed after reset or a block
// count write: a per-pool high-water mark makes unwritten stack entries read as their own
// index. The next item is accepted while a result still waits in the output register.
`default_nettype none
module multi_pool_block_allocator_top #(
	parameter int MAX_BLOCKS = 256,
	parameter int REGION_BITS = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] func,
	input wire logic [15:0] request_size,
	input wire logic has_address,
	input wire logic [REGION_BITS+1:0] address,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] status,
	output logic [REGION_BITS+1:0] result_address,
	output logic [1:0] pool_index,
	output logic [12:0] copy_length,
	output logic old_released,
	input wire logic cfg_we,
	input wire logic [mpba_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [mpba_pkg::CFG_W-1:0] cfg_data
);
	`include "multi_pool_block_allocator_top_macros.svh"

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int AW = REGION_BITS + 2;
	localparam int SW = mpba_pkg::SIZE_W;
	localparam int EW = CW + SW;
	localparam int PW = SW + IW;
	localparam int CMPW = (EW > REGION_BITS) ? EW : REGION_BITS;
	localparam int CNT_RST = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

	// configuration registers
	logic [1:0] pools_q;
	logic [2:0][SW-1:0] size_q;
	logic [2:0][CW-1:0] count_q;
	logic fallback_q;
	logic [2:0] refill;
	logic [SW-1:0] size_sat;
	logic [CW-1:0] count_sat;

	assign size_sat = (cfg_data > mpba_pkg::SIZE_MAX) ? mpba_pkg::SIZE_MAX : cfg_data;
	assign count_sat = (32'(cfg_data[8:0]) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(cfg_data[8:0]);
	assign refill[0] = cfg_we && cfg_index == mpba_pkg::REG_COUNT_A;
	assign refill[1] = cfg_we && cfg_index == mpba_pkg::REG_COUNT_B;
	assign refill[2] = cfg_we && cfg_index == mpba_pkg::REG_COUNT_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pools_q <= 2'd3;
			size_q[0] <= SW'(16);
			size_q[1] <= SW'(64);
			size_q[2] <= SW'(256);
			count_q <= {3{CW'(CNT_RST)}};
			fallback_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				mpba_pkg::REG_POOLS: pools_q <= cfg_data[1:0];
				mpba_pkg::REG_SIZE_A: size_q[0] <= size_sat;
				mpba_pkg::REG_COUNT_A: count_q[0] <= count_sat;
				mpba_pkg::REG_SIZE_B: size_q[1] <= size_sat;
				mpba_pkg::REG_COUNT_B: count_q[1] <= count_sat;
				mpba_pkg::REG_SIZE_C: size_q[2] <= size_sat;
				mpba_pkg::REG_COUNT_C: count_q[2] <= count_sat;
				mpba_pkg::REG_FALLBACK: fallback_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item registers
	mpba_pkg::state_t state_q, state_nx;
	logic [1:0] func_q;
	logic [15:0] req_q;
	logic move_q;
	logic [AW-1:0] addr_q;
	logic [1:0] ap;
	logic [REGION_BITS-1:0] aoff;
	logic [SW-1:0] ap_size;
	logic [CW-1:0] ap_count, ap_sp;
	logic [EW-1:0] end_s1;
	logic in_region;

	// working result
	logic [1:0] w_status, w_pool;
	logic [AW-1:0] w_addr;
	logic [SW-1:0] w_copy;
	logic w_rel;
	logic [1:0] sel_q;

	// stack and divider
	mpba_pkg::stack_cmd_t cmd;
	logic [2:0][CW-1:0] sp;
	logic [IW-1:0] pop_data;
	logic div_start, div_busy;
	logic [REGION_BITS-1:0] quotient;

	// pool search
	logic [2:0] cand;
	logic found;
	logic [1:0] found_pool;
	logic [SW-1:0] sel_size;
	logic [PW-1:0] prod;
	logic in_acc, out_load;

	assign ap = addr_q[AW-1:REGION_BITS];
	assign aoff = addr_q[REGION_BITS-1:0];

	// settings of the pool named by the address
	always_comb begin
		case (ap)
			2'd0: begin ap_size = size_q[0]; ap_count = count_q[0]; ap_sp = sp[0]; end
			2'd1: begin ap_size = size_q[1]; ap_count = count_q[1]; ap_sp = sp[1]; end
			2'd2: begin ap_size = size_q[2]; ap_count = count_q[2]; ap_sp = sp[2]; end
			default: begin ap_size = '0; ap_count = '0; ap_sp = '0; end
		endcase
	end

	assign in_region = ap != mpba_pkg::POOL_NONE && ap < pools_q &&
		CMPW'(aoff) < CMPW'(end_s1);

	// first pool in order that fits and has a free block
	always_comb begin
		for (int i = 0; i < mpba_pkg::NPOOLS; i++)
			cand[i] = 2'(i) < pools_q && size_q[i] != '0 &&
				{3'b0, size_q[i]} >= req_q && sp[i] < count_q[i];
		found = |cand;
		if (cand[0])
			found_pool = 2'd0;
		else if (cand[1])
			found_pool = 2'd1;
		else
			found_pool = 2'd2;
	end

	// block size of the pool that was popped
	always_comb begin
		case (sel_q)
			2'd0: sel_size = size_q[0];
			2'd1: sel_size = size_q[1];
			2'd2: sel_size = size_q[2];
			default: sel_size = '0;
		endcase
	end
	assign prod = PW'(sel_size) * PW'(pop_data);

	assign in_acc = in_valid && in_ready;
	assign out_load = state_q == mpba_pkg::S_RESP && (!out_valid || out_ready);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			mpba_pkg::S_IDLE:
				if (in_acc) begin
					if (func == mpba_pkg::FUNC_ALLOC ||
						(func == mpba_pkg::FUNC_RESIZE && !has_address))
						state_nx = mpba_pkg::S_ALLOC_RD;
					else if ((func == mpba_pkg::FUNC_RELEASE ||
						func == mpba_pkg::FUNC_RESIZE) && has_address)
						state_nx = mpba_pkg::S_REGION;
					else
						state_nx = mpba_pkg::S_RESP;
				end
			mpba_pkg::S_REGION: state_nx = mpba_pkg::S_FIND;
			mpba_pkg::S_FIND:
				if (!in_region)
					state_nx = mpba_pkg::S_RESP;
				else if (func_q == mpba_pkg::FUNC_RELEASE)
					state_nx = mpba_pkg::S_DIV_GO;
				else if ({3'b0, ap_size} >= req_q)
					state_nx = mpba_pkg::S_RESP;
				else
					state_nx = mpba_pkg::S_ALLOC_RD;
			mpba_pkg::S_ALLOC_RD:
				if (found)
					state_nx = mpba_pkg::S_ALLOC_WB;
				else
					state_nx = move_q ? mpba_pkg::S_DIV_GO : mpba_pkg::S_RESP;
			mpba_pkg::S_ALLOC_WB:
				state_nx = move_q ? mpba_pkg::S_DIV_GO : mpba_pkg::S_RESP;
			mpba_pkg::S_DIV_GO: state_nx = mpba_pkg::S_DIV;
			mpba_pkg::S_DIV: if (!div_busy) state_nx = mpba_pkg::S_PUSH;
			mpba_pkg::S_PUSH: state_nx = mpba_pkg::S_RESP;
			mpba_pkg::S_RESP: if (out_load) state_nx = mpba_pkg::S_IDLE;
			default: state_nx = mpba_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = state_q == mpba_pkg::S_IDLE;
		div_start = state_q == mpba_pkg::S_DIV_GO;
		cmd = '0;
		case (state_q)
			mpba_pkg::S_ALLOC_RD: begin
				cmd.pop = found;
				cmd.pool = found_pool;
			end
			mpba_pkg::S_PUSH: begin
				cmd.push = ap_sp != '0;
				cmd.pool = ap;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mpba_pkg::S_IDLE;
		else
			state_q <= state_nx;
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mpba_pkg::S_IDLE:
				if (in_acc) begin
					func_q <= func;
					req_q <= request_size;
					addr_q <= address;
					move_q <= 1'b0;
					w_status <= mpba_pkg::ST_FAILED;
					w_pool <= mpba_pkg::POOL_NONE;
					w_addr <= '0;
					w_copy <= '0;
					w_rel <= 1'b0;
				end
			mpba_pkg::S_REGION: end_s1 <= EW'(ap_count) * EW'(ap_size);
			mpba_pkg::S_FIND:
				if (!in_region) begin
					w_status <= mpba_pkg::ST_EXTERNAL;
				end else if (func_q == mpba_pkg::FUNC_RELEASE) begin
					w_pool <= ap;
				end else if ({3'b0, ap_size} >= req_q) begin
					w_status <= mpba_pkg::ST_DONE;
					w_addr <= addr_q;
					w_pool <= ap;
				end else begin
					w_copy <= ap_size;
					move_q <= 1'b1;
				end
			mpba_pkg::S_ALLOC_RD:
				if (found)
					sel_q <= found_pool;
				else
					w_status <= fallback_q ? mpba_pkg::ST_EXTERNAL : mpba_pkg::ST_FAILED;
			mpba_pkg::S_ALLOC_WB: begin
				w_status <= mpba_pkg::ST_DONE;
				w_pool <= sel_q;
				w_addr <= {sel_q, REGION_BITS'(prod)};
			end
			mpba_pkg::S_PUSH:
				if (ap_sp == '0) begin
					w_status <= mpba_pkg::ST_UNDERFLOW;
					w_addr <= '0;
				end else if (move_q) begin
					w_rel <= 1'b1;
				end else begin
					w_status <= mpba_pkg::ST_DONE;
				end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status <= w_status;
			result_address <= (w_status == mpba_pkg::ST_DONE) ? w_addr : '0;
			pool_index <= w_pool;
			copy_length <= w_copy;
			old_released <= w_rel;
		end
	end

	mpba_stack #(.MAX_BLOCKS(MAX_BLOCKS)) u_stack (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.push_data(IW'(quotient)),
		.refill(refill),
		.sp(sp),
		.pop_data(pop_data)
	);

	mpba_div #(.WIDTH(REGION_BITS)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(aoff),
		.divisor(ap_size),
		.busy(div_busy),
		.quotient(quotient)
	);

	// checks
	`MPBA_ASSERT_NOW(a_no_underflow_push, cmd.push, ap_sp != '0, "push on empty stack")
	`MPBA_ASSERT_NOW(a_pop_has_free, cmd.pop, cand[cmd.pool], "pop from pool without free block")
	`MPBA_ASSERT_NEXT(a_resp_loads, out_load, out_valid && state_q == mpba_pkg::S_IDLE,
		"result not loaded")
	`MPBA_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready, "item accepted while busy")
endmodule
`default_nettype wire

FILE: rtl/mpba_stack.sv
// free index stacks of all pools in one ram, with pointers and high-water marks
`default_nettype none
module mpba_stack #(
	parameter int MAX_BLOCKS = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire mpba_pkg::stack_cmd_t cmd,
	input wire logic [$clog2(MAX_BLOCKS)-1:0] push_data,
	input wire logic [2:0] refill,
	output logic [2:0][$clog2(MAX_BLOCKS+1)-1:0] sp,
	output logic [$clog2(MAX_BLOCKS)-1:0] pop_data
);
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int DEPTH = mpba_pkg::NPOOLS * MAX_BLOCKS;
	localparam int RAW = $clog2(DEPTH);

	logic [IW-1:0] ram [DEPTH];
	logic [2:0][CW-1:0] sp_q, hw_q;
	logic [CW-1:0] sel_sp, sel_hw;
	logic [IW-1:0] idx;
	logic [RAW-1:0] ram_addr;
	logic [IW-1:0] rdata_s1, idx_s1;
	logic fresh_s1;

	// pointer and mark of the addressed pool
	always_comb begin
		case (cmd.pool)
			2'd0: begin sel_sp = sp_q[0]; sel_hw = hw_q[0]; end
			2'd1: begin sel_sp = sp_q[1]; sel_hw = hw_q[1]; end
			2'd2: begin sel_sp = sp_q[2]; sel_hw = hw_q[2]; end
			default: begin sel_sp = '0; sel_hw = '0; end
		endcase
	end

	// pop reads at the pointer, push writes just below it
	assign idx = cmd.push ? IW'(sel_sp - CW'(1)) : IW'(sel_sp);
	assign ram_addr = RAW'(32'(cmd.pool) * MAX_BLOCKS + 32'(idx));

	// ram port
	always_ff @(posedge clk) begin
		if (cmd.push)
			ram[ram_addr] <= push_data;
		if (cmd.pop) begin
			rdata_s1 <= ram[ram_addr];
			idx_s1 <= idx;
			fresh_s1 <= CW'(idx) >= sel_hw;
		end
	end

	// entries at or above the mark were never written since refill and hold their index
	assign pop_data = fresh_s1 ? idx_s1 : rdata_s1;

	// pointers and marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			hw_q <= '0;
		end else begin
			for (int p = 0; p < mpba_pkg::NPOOLS; p++) begin
				if (refill[p]) begin
					sp_q[p] <= '0;
					hw_q[p] <= '0;
				end else if (cmd.pop && cmd.pool == 2'(p)) begin
					sp_q[p] <= sp_q[p] + CW'(1);
				end else if (cmd.push && cmd.pool == 2'(p)) begin
					sp_q[p] <= sp_q[p] - CW'(1);
					if (sp_q[p] > hw_q[p])
						hw_q[p] <= sp_q[p];
				end
			end
		end
	end

	assign sp = sp_q;
endmodule
`default_nettype wire

FILE: rtl/mpba_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module mpba_div #(
	parameter int WIDTH = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [WIDTH-1:0] dividend,
	input wire logic [mpba_pkg::SIZE_W-1:0] divisor,
	output logic busy,
	output logic [WIDTH-1:0] quotient
);
	localparam int SW = mpba_pkg::SIZE_W;
	localparam int NW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] num_q;
	logic [SW-1:0] den_q, rem_q;
	logic [NW-1:0] cnt_q;
	logic busy_q;
	logic [SW:0] trial;
	logic ge;

	// shift next dividend bit into the remainder and try a subtract
	assign trial = {rem_q, num_q[WIDTH-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= NW'(WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - NW'(1);
			if (cnt_q == NW'(1))
				busy_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? SW'(trial - {1'b0, den_q}) : SW'(trial);
			num_q <= {num_q[WIDTH-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quotient = num_q;
endmodule
`default_nettype wire
